/* src/msort_pkg.sv */
package msort_pkg;

  // Number of values one set may hold; it is also the number of cells in the row.
  localparam int unsigned CAPACITY = 64;
  localparam int unsigned DATA_W   = 32;
  // Wide enough to hold the value CAPACITY itself.
  localparam int unsigned CNT_W    = $clog2(CAPACITY + 1);

  // One slot of the cell row: a held value or a value travelling to the right.
  typedef struct packed {
    logic                     valid;
    logic signed [DATA_W-1:0] value;
  } cell_entry_t;

  // Row-wide control. Only one of the shifts is raised at a time.
  typedef struct packed {
    logic shift_left;
    logic shift_right;
  } cell_ctrl_t;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_DRAIN,
    ST_ALIGN,
    ST_EMIT
  } state_e;

endpackage

/* src/msort_cell.sv */
module msort_cell (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  msort_pkg::cell_ctrl_t  ctrl_i,
  input  msort_pkg::cell_entry_t carry_i,
  input  msort_pkg::cell_entry_t left_i,
  input  msort_pkg::cell_entry_t right_i,
  output msort_pkg::cell_entry_t hold_o,
  output msort_pkg::cell_entry_t carry_o
);

  msort_pkg::cell_entry_t hold_q, hold_d;
  msort_pkg::cell_entry_t carry_q, carry_d;
  logic                   takes_carry;

  // The arriving value displaces the held one when it is smaller or the cell is empty.
  assign takes_carry = carry_i.valid &&
                       (!hold_q.valid || ($signed(carry_i.value) < $signed(hold_q.value)));

  // Insertion step, or a plain shift during the align and output phases.
  always_comb begin
    hold_d  = hold_q;
    carry_d = '0;
    if (ctrl_i.shift_left) begin
      hold_d = right_i;
    end else if (ctrl_i.shift_right) begin
      hold_d = left_i;
    end else if (takes_carry) begin
      hold_d  = carry_i;
      carry_d = hold_q;
    end else if (carry_i.valid) begin
      carry_d = carry_i;
    end
  end

  // Cell registers; reset leaves the cell empty with nothing travelling.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_q  <= '0;
      carry_q <= '0;
    end else begin
      hold_q  <= hold_d;
      carry_q <= carry_d;
    end
  end

  assign hold_o  = hold_q;
  assign carry_o = carry_q;

endmodule

/* src/msort_chain.sv */
module msort_chain (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  msort_pkg::cell_ctrl_t  ctrl_i,
  input  msort_pkg::cell_entry_t insert_i,
  output msort_pkg::cell_entry_t head_lo_o,
  output msort_pkg::cell_entry_t head_hi_o
);

  msort_pkg::cell_entry_t hold  [msort_pkg::CAPACITY];
  msort_pkg::cell_entry_t carry [msort_pkg::CAPACITY];
  msort_pkg::cell_entry_t carry_in [msort_pkg::CAPACITY];
  msort_pkg::cell_entry_t left_in  [msort_pkg::CAPACITY];
  msort_pkg::cell_entry_t right_in [msort_pkg::CAPACITY];

  // Neighbour wiring: the row ends shift in empty slots.
  for (genvar i = 0; i < msort_pkg::CAPACITY; i++) begin : g_cell
    if (i == 0) begin : g_first
      assign carry_in[i] = insert_i;
      assign left_in[i]  = '0;
    end else begin : g_inner
      assign carry_in[i] = carry[i-1];
      assign left_in[i]  = hold[i-1];
    end
    if (i == msort_pkg::CAPACITY - 1) begin : g_last
      assign right_in[i] = '0;
    end else begin : g_notlast
      assign right_in[i] = hold[i+1];
    end

    msort_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctrl_i  (ctrl_i),
      .carry_i (carry_in[i]),
      .left_i  (left_in[i]),
      .right_i (right_in[i]),
      .hold_o  (hold[i]),
      .carry_o (carry[i])
    );
  end

  assign head_lo_o = hold[0];
  assign head_hi_o = hold[msort_pkg::CAPACITY-1];

endmodule

/* src/merge_sorter_top.sv */
// Channel   Direction  Handshake                       Payload
// s_axis    in         s_axis_tvalid_i/s_axis_tready_o tdata: value; tlast: is_last
// m_axis    out        m_axis_tvalid_o/m_axis_tready_i tdata: sorted_value; tlast: end_of_set;
//                                                       tuser: overflowed
// cfg       in         cfg_valid_i/cfg_ready_o         data: descending
//
// Values are taken one per cycle while a set is loaded; each enters a row of CAPACITY
// cells that keeps them in ascending order by systolic insertion.
// After the transfer flagged last the row drains; a descending set then shifts right until
// its largest value is seen at the far cell.
// Results then leave one per cycle from an output register; a stall halts the row.
// Reset clears all valid bits; no input is taken from the last-flagged transfer until the
// final result of the set has been moved into the output register.
module merge_sorter_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [31:0] s_axis_tdata_i,   // [31:0] value
  input  logic        s_axis_tlast_i,   // is_last
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o,   // [31:0] sorted_value
  output logic        m_axis_tlast_o,   // end_of_set
  output logic [0:0]  m_axis_tuser_o,   // [0] overflowed
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [0:0]  cfg_data_i        // [0] descending
);

  localparam int unsigned CntW = msort_pkg::CNT_W;

  msort_pkg::state_e       state_q, state_d;
  logic [CntW-1:0]         count_q, count_d;
  logic [CntW-1:0]         remain_q, remain_d;
  logic [CntW-1:0]         drain_q, drain_d;
  logic                    ovf_q, ovf_d;
  logic                    set_ovf_q, set_ovf_d;
  logic                    desc_q;
  logic                    dir_q, dir_d;
  logic                    out_valid_q, out_valid_d;
  logic signed [31:0]      out_data_q, out_data_d;
  logic                    out_last_q, out_last_d;
  logic                    out_ovf_q, out_ovf_d;

  logic                    in_xfer;
  logic                    room;
  logic                    out_free;
  logic                    emit;
  msort_pkg::cell_ctrl_t   ctrl;
  msort_pkg::cell_entry_t  insert;
  msort_pkg::cell_entry_t  head_lo, head_hi, head;

  assign cfg_ready_o = 1'b1;

  // Configuration register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      desc_q <= 1'b0;
    end else if (cfg_valid_i) begin
      desc_q <= cfg_data_i[0];
    end
  end

  assign s_axis_tready_o = (state_q == msort_pkg::ST_LOAD);
  assign in_xfer  = s_axis_tvalid_i && s_axis_tready_o;
  assign room     = (count_q < CntW'(msort_pkg::CAPACITY));
  assign out_free = !out_valid_q || m_axis_tready_i;
  assign head     = dir_q ? head_hi : head_lo;

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      msort_pkg::ST_LOAD: begin
        if (in_xfer && s_axis_tlast_i) begin
          state_d = msort_pkg::ST_DRAIN;
        end
      end
      msort_pkg::ST_DRAIN: begin
        if (drain_q == CntW'(1)) begin
          state_d = dir_q ? msort_pkg::ST_ALIGN : msort_pkg::ST_EMIT;
        end
      end
      msort_pkg::ST_ALIGN: begin
        if (head_hi.valid) begin
          state_d = msort_pkg::ST_EMIT;
        end
      end
      msort_pkg::ST_EMIT: begin
        if (out_free && (remain_q == CntW'(1))) begin
          state_d = msort_pkg::ST_LOAD;
        end
      end
      default: state_d = msort_pkg::ST_LOAD;
    endcase
  end

  // Datapath and row control.
  always_comb begin
    count_d     = count_q;
    remain_d    = remain_q;
    drain_d     = drain_q;
    ovf_d       = ovf_q;
    set_ovf_d   = set_ovf_q;
    dir_d       = dir_q;
    out_data_d  = out_data_q;
    out_last_d  = out_last_q;
    out_ovf_d   = out_ovf_q;
    out_valid_d = out_valid_q && !m_axis_tready_i;
    insert      = '0;
    ctrl        = '0;
    emit        = 1'b0;
    case (state_q)
      msort_pkg::ST_LOAD: begin
        if (in_xfer) begin
          if (room) begin
            insert.valid = 1'b1;
            insert.value = $signed(s_axis_tdata_i);
          end
          if (s_axis_tlast_i) begin
            remain_d  = room ? (count_q + CntW'(1)) : count_q;
            set_ovf_d = ovf_q || !room;
            dir_d     = desc_q;
            drain_d   = CntW'(msort_pkg::CAPACITY);
            count_d   = '0;
            ovf_d     = 1'b0;
          end else if (room) begin
            count_d = count_q + CntW'(1);
          end else begin
            ovf_d = 1'b1;
          end
        end
      end
      msort_pkg::ST_DRAIN: begin
        drain_d = drain_q - CntW'(1);
      end
      msort_pkg::ST_ALIGN: begin
        ctrl.shift_right = !head_hi.valid;
      end
      msort_pkg::ST_EMIT: begin
        emit = out_free;
      end
      default: begin
      end
    endcase
    // One result moves from the head cell into the output register.
    if (emit) begin
      out_valid_d      = 1'b1;
      out_data_d       = head.value;
      out_last_d       = (remain_q == CntW'(1));
      out_ovf_d        = set_ovf_q;
      remain_d         = remain_q - CntW'(1);
      ctrl.shift_left  = !dir_q;
      ctrl.shift_right = dir_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= msort_pkg::ST_LOAD;
      count_q     <= '0;
      remain_q    <= '0;
      drain_q     <= '0;
      ovf_q       <= 1'b0;
      set_ovf_q   <= 1'b0;
      dir_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      remain_q    <= remain_d;
      drain_q     <= drain_d;
      ovf_q       <= ovf_d;
      set_ovf_q   <= set_ovf_d;
      dir_q       <= dir_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
    out_last_q <= out_last_d;
    out_ovf_q  <= out_ovf_d;
  end

  msort_chain u_chain (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (ctrl),
    .insert_i  (insert),
    .head_lo_o (head_lo),
    .head_hi_o (head_hi)
  );

  assign m_axis_tvalid_o   = out_valid_q;
  assign m_axis_tdata_o    = out_data_q;
  assign m_axis_tlast_o    = out_last_q;
  assign m_axis_tuser_o[0] = out_ovf_q;

endmodule

/* tb/tb_merge_sorter_top.sv */
`timescale 1ns / 1ps

module tb_merge_sorter_top;

  localparam int unsigned STALL_LIMIT  = 3000;
  localparam int unsigned SETTLE_TICKS = 8;
  localparam int unsigned TAIL_TICKS   = 16;
  localparam int unsigned REPORT_MAX   = 10;

  localparam logic signed [msort_pkg::DATA_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [msort_pkg::DATA_W-1:0] VAL_MIN = 32'sh8000_0000;

  // One sorted element as it leaves the block.
  typedef struct packed {
    logic signed [msort_pkg::DATA_W-1:0] value;
    logic                                end_of_set;
    logic                                overflowed;
  } sorted_out_t;

  // One row of the directed table; want is only meaningful when typed is set.
  typedef struct packed {
    logic signed [msort_pkg::DATA_W-1:0] value;
    logic                                is_last;
    logic                                typed;
    sorted_out_t                         want;
  } stim_row_t;

  // Single-value sets have an obvious answer; longer sets go through the predictor.
  localparam stim_row_t DIRECTED_ROWS [13] = '{
    '{VAL_MAX,      1'b1, 1'b1, '{VAL_MAX,      1'b1, 1'b0}},
    '{VAL_MIN,      1'b1, 1'b1, '{VAL_MIN,      1'b1, 1'b0}},
    '{32'sd0,       1'b1, 1'b1, '{32'sd0,       1'b1, 1'b0}},
    '{-32'sd1,      1'b1, 1'b1, '{-32'sd1,      1'b1, 1'b0}},
    '{32'sd5,       1'b0, 1'b0, '0},
    '{-32'sd3,      1'b0, 1'b0, '0},
    '{VAL_MAX,      1'b0, 1'b0, '0},
    '{VAL_MIN,      1'b0, 1'b0, '0},
    '{32'sd0,       1'b1, 1'b0, '0},
    '{32'sd7,       1'b0, 1'b0, '0},
    '{32'sd7,       1'b0, 1'b0, '0},
    '{-32'sd7,      1'b0, 1'b0, '0},
    '{32'sd7,       1'b1, 1'b0, '0}
  };

  logic                         clk;
  logic                         rst_n;
  logic                         s_tvalid;
  logic                         s_tready;
  logic [msort_pkg::DATA_W-1:0] s_tdata;
  logic                         s_tlast;
  logic                         m_tvalid;
  logic                         m_tready;
  logic [msort_pkg::DATA_W-1:0] m_tdata;
  logic                         m_tlast;
  logic [0:0]                   m_tuser;
  logic                         cfg_valid;
  logic                         cfg_ready;
  logic [0:0]                   cfg_data;

  // Predictor state: the values held for the open set, and the sort order.
  logic signed [msort_pkg::DATA_W-1:0] held_values[$];
  logic                                held_overflow;
  logic                                sort_descending;

  sorted_out_t sorted_expected[$];
  sorted_out_t got_result;
  sorted_out_t want_result;
  int          mismatch_count;
  int          quiet_cycles;
  int          idle_pct;
  int          stall_pct;

  merge_sorter_top u_dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),   // [31:0] value
    .s_axis_tlast_i  (s_tlast),   // is_last
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),   // [31:0] sorted_value
    .m_axis_tlast_o  (m_tlast),   // end_of_set
    .m_axis_tuser_o  (m_tuser),   // [0] overflowed
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_data_i      (cfg_data)   // [0] descending
  );

  always #5 clk = ~clk;

  // Takes one accepted value into the open set; a closing value yields the sorted set.
  function automatic void absorb_value(input logic signed [msort_pkg::DATA_W-1:0] v,
                                       input logic closes, output sorted_out_t produced[$]);
    logic signed [msort_pkg::DATA_W-1:0] ordered[$];
    logic signed [msort_pkg::DATA_W-1:0] key;
    int                                  j;
    sorted_out_t                         item;
    produced.delete();
    if (held_values.size() < msort_pkg::CAPACITY) begin
      held_values.insert(held_values.size(), v);
    end else begin
      held_overflow = 1'b1;
    end
    if (closes) begin
      ordered = held_values;
      // Insertion sort; ties cannot be told apart for plain integers.
      for (int i = 1; i < ordered.size(); i++) begin
        key = ordered[i];
        j   = i;
        while (j > 0 && (sort_descending ? (key > ordered[j-1]) : (key < ordered[j-1]))) begin
          ordered[j] = ordered[j-1];
          j--;
        end
        ordered[j] = key;
      end
      foreach (ordered[k]) begin
        item.value      = ordered[k];
        item.end_of_set = (k == ordered.size() - 1);
        item.overflowed = held_overflow;
        produced.insert(produced.size(), item);
      end
      held_values.delete();
      held_overflow = 1'b0;
    end
  endfunction

  // Biased value choice: extremes and near-duplicates turn up often.
  function automatic logic signed [msort_pkg::DATA_W-1:0] pick_value();
    case ($urandom_range(15))
      0:       return VAL_MIN;
      1:       return VAL_MAX;
      2:       return '0;
      3:       return '1;
      4, 5:    return 32'($urandom_range(8)) - 32'd4;
      default: return $urandom;
    endcase
  endfunction

  // Presents one value and waits for its transfer; called at a rising edge.
  task automatic send_value(input logic signed [msort_pkg::DATA_W-1:0] v, input logic closes,
                            input logic typed, input sorted_out_t want);
    sorted_out_t produced[$];
    bit          taken;
    while ($urandom_range(99) < idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= v;
    s_tlast  <= closes;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk);
      taken = s_tready;
      @(posedge clk);
    end
    absorb_value(v, closes, produced);
    if (typed) begin
      sorted_expected.insert(sorted_expected.size(), want);
    end else begin
      foreach (produced[k]) sorted_expected.insert(sorted_expected.size(), produced[k]);
    end
  endtask

  // Stops sending and waits until every expected element has left the block.
  task automatic drain_results();
    s_tvalid <= 1'b0;
    while (sorted_expected.size() != 0) @(posedge clk);
    repeat (SETTLE_TICKS) @(posedge clk);
  endtask

  // Writes the sort order once the block has gone idle.
  task automatic write_descending(input logic d);
    bit taken;
    drain_results();
    cfg_valid <= 1'b1;
    cfg_data  <= d;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk);
      taken = cfg_ready;
      @(posedge clk);
    end
    sort_descending = d;
    cfg_valid <= 1'b0;
  endtask

  task automatic walk_directed();
    foreach (DIRECTED_ROWS[r]) begin
      send_value(DIRECTED_ROWS[r].value, DIRECTED_ROWS[r].is_last, DIRECTED_ROWS[r].typed,
                 DIRECTED_ROWS[r].want);
    end
  endtask

  // Random sets of mostly small size, optionally followed by one set past capacity.
  task automatic run_phase(input logic d, input int src_idle, input int snk_stall,
                           input int quota, input bit oversize);
    int sent;
    int set_len;
    write_descending(d);
    idle_pct  = src_idle;
    stall_pct = snk_stall;
    sent = 0;
    while (sent < quota) begin
      set_len = ($urandom_range(7) == 0) ? $urandom_range(24, 9) : $urandom_range(8, 1);
      for (int k = 0; k < set_len; k++) begin
        send_value(pick_value(), (k == set_len - 1), 1'b0, '0);
      end
      sent += set_len;
      // Now and then let the block empty completely before the next set.
      if ($urandom_range(5) == 0) drain_results();
    end
    // Two values beyond capacity: one plain, then the closing one, both dropped.
    if (oversize) begin
      for (int k = 0; k < msort_pkg::CAPACITY + 2; k++) begin
        send_value(pick_value(), (k == msort_pkg::CAPACITY + 1), 1'b0, '0);
      end
    end
  endtask

  // Receiver readiness, redrawn at every rising edge.
  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= stall_pct);
  end

  // Outputs are stable at the falling edge, so transfers are judged there.
  always @(negedge clk) begin
    if (rst_n) begin
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (m_tvalid && m_tready) begin
        got_result = '{m_tdata, m_tlast, m_tuser[0]};
        if (sorted_expected.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_MAX) begin
            $display("%0t: unexpected element value %0d last %0b overflow %0b", $realtime,
                     got_result.value, got_result.end_of_set, got_result.overflowed);
          end
        end else begin
          want_result = sorted_expected.pop_front();
          if (got_result.value !== want_result.value ||
              got_result.end_of_set !== want_result.end_of_set ||
              got_result.overflowed !== want_result.overflowed) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_MAX) begin
              $display("%0t: expected value %0d last %0b overflow %0b, got %0d %0b %0b",
                       $realtime, want_result.value, want_result.end_of_set,
                       want_result.overflowed, got_result.value, got_result.end_of_set,
                       got_result.overflowed);
            end
          end
        end
      end
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  initial begin
    clk             = 1'b0;
    rst_n           = 1'b0;
    s_tvalid        = 1'b0;
    s_tdata         = '0;
    s_tlast         = 1'b0;
    cfg_valid       = 1'b0;
    cfg_data        = '0;
    held_overflow   = 1'b0;
    sort_descending = 1'b0;
    mismatch_count  = 0;
    quiet_cycles    = 0;
    idle_pct        = 0;
    stall_pct       = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed sets in both orders.
    write_descending(1'b0);
    walk_directed();
    write_descending(1'b1);
    walk_directed();

    // Random sets under each idling pattern; the stalled phase also overflows the store.
    run_phase(1'b1, 0, 0, 15, 1'b0);
    run_phase(1'b0, 60, 0, 15, 1'b0);
    run_phase(1'b1, 0, 60, 15, 1'b1);
    run_phase(1'b0, 11, 11, 15, 1'b0);

    drain_results();
    repeat (TAIL_TICKS) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
